// ===== rtl/bvwpm_pkg.sv =====
// Shared constants, types and helper functions for the banked memory map.
package bvwpm_pkg;

  localparam int PALETTE_BYTES = 64;
  localparam int WORK_BANKS    = 8;

  localparam int VRAM_DEPTH     = 16384;
  localparam int VRAM_AW        = $clog2(VRAM_DEPTH);
  localparam int WRAM_BANK_SIZE = 4096;
  localparam int WRAM_DEPTH     = WORK_BANKS * WRAM_BANK_SIZE;
  localparam int WRAM_AW        = $clog2(WRAM_DEPTH);
  localparam int WBANK_W        = WRAM_AW - 12;
  localparam int SPRITE_DEPTH   = 160;
  localparam int SPRITE_AW      = $clog2(SPRITE_DEPTH);
  localparam int HRAM_DEPTH     = 127;
  localparam int HRAM_AW        = $clog2(HRAM_DEPTH);
  localparam int PAL_AW         = $clog2(PALETTE_BYTES);

  // Region bounds
  localparam logic [15:0] ADDR_CART       = 16'hA000;
  localparam logic [15:0] ADDR_WRAM       = 16'hC000;
  localparam logic [15:0] ADDR_WRAM_SW    = 16'hD000;
  localparam logic [15:0] ADDR_ECHO       = 16'hE000;
  localparam logic [15:0] ADDR_SPRITE     = 16'hFE00;
  localparam logic [15:0] ADDR_SPRITE_END = 16'hFEA0;
  localparam logic [15:0] ADDR_IO         = 16'hFF00;

  // Single-byte registers
  localparam logic [15:0] ADDR_VBANK = 16'hFF4F;
  localparam logic [15:0] ADDR_BPI   = 16'hFF68;
  localparam logic [15:0] ADDR_BPD   = 16'hFF69;
  localparam logic [15:0] ADDR_OPI   = 16'hFF6A;
  localparam logic [15:0] ADDR_OPD   = 16'hFF6B;
  localparam logic [15:0] ADDR_WBANK = 16'hFF70;
  localparam logic [15:0] ADDR_IE    = 16'hFFFF;

  localparam logic [7:0] BYTE_OPEN = 8'hFF;

  typedef struct packed {
    logic issue;  // word accepted: decode and start the memory access
    logic load;   // move the finished result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;  // captured access lies at 0x8000 or above
  } dp_status_t;

  // Switchable work bank: 0 selects 1, then wrap by the bank count
  function automatic logic [WBANK_W-1:0] wram_bank_wrap(input logic [2:0] bank);
    logic [3:0] b;
    b = (bank == 3'd0) ? 4'd1 : {1'b0, bank};
    for (int i = 0; i < 4; i++) begin
      if (b >= 4'(WORK_BANKS)) b = b - 4'(WORK_BANKS);
    end
    return b[WBANK_W-1:0];
  endfunction

  // Palette entry from index bits 5..0, wrapped by the palette size
  function automatic logic [PAL_AW-1:0] pal_wrap(input logic [5:0] idx);
    logic [6:0] b;
    b = {1'b0, idx};
    for (int i = 0; i < 8; i++) begin
      if (b >= 7'(PALETTE_BYTES)) b = b - 7'(PALETTE_BYTES);
    end
    return b[PAL_AW-1:0];
  endfunction

  // Next palette entry after an auto-increment write
  function automatic logic [5:0] pal_next(input logic [PAL_AW-1:0] e);
    logic [6:0] s;
    s = 7'(e) + 7'd1;
    if (s == 7'(PALETTE_BYTES)) s = '0;
    return s[5:0];
  endfunction

endpackage

// ===== rtl/bvwpm_req_if.sv =====
// Bus access channel: valid/ready with access type, address and write byte.
interface bvwpm_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, output req_type, output bus_address, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input bus_address, input write_data,
                  output ready);
endinterface

// ===== rtl/bvwpm_rsp_if.sv =====
// Result channel: valid/ready with read byte and claim flag.
interface bvwpm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       claimed;

  modport source (output valid, output read_data, output claimed, input ready);
  modport sink   (input valid, input read_data, input claimed, output ready);
endinterface

// ===== rtl/bvwpm_cfg_if.sv =====
// Configuration write channel: valid/ready with the colour mode bit.
interface bvwpm_cfg_if;
  logic valid;
  logic ready;
  logic color_mode;

  modport source (output valid, output color_mode, input ready);
  modport sink   (input valid, input color_mode, output ready);
endinterface

// ===== rtl/bvwpm_ram.sv =====
// Generic single-port RAM with registered read data.
module bvwpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bvwpm_ctrl.sv =====
// Controller: sequences accept, memory access and result load.
module bvwpm_ctrl
  import bvwpm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    in_ready_o   = (state_q == S_IDLE);
    cmd_o.issue  = in_valid_i && (state_q == S_IDLE);
    cmd_o.load   = (state_q == S_RESP) && status_i.has_result &&
                   (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.issue) state_q <= S_RESP;
        end
        S_RESP: begin
          // no result below 0x8000; otherwise wait for the output register
          if (!status_i.has_result || cmd_o.load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase

      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/bvwpm_datapath.sv =====
// Datapath: address decode, memories, bank and palette registers, result register.
module bvwpm_datapath
  import bvwpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  logic        req_type_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_color_mode_i,
  output logic [7:0]  read_data_o,
  output logic        claimed_o
);

  typedef enum logic [2:0] {
    SRC_FIXED,
    SRC_VRAM,
    SRC_WRAM,
    SRC_SPRITE,
    SRC_HRAM,
    SRC_BPAL,
    SRC_OPAL
  } src_e;

  // Architectural registers
  logic       color_mode_q;
  logic       vbank_q;
  logic [2:0] wbank_q;
  logic [7:0] bpi_q;
  logic [7:0] opi_q;
  logic [7:0] ie_q;

  // Access captured for the response cycle
  src_e       src_q, src_d;
  logic [7:0] fix_q, fix_d;
  logic       claim_q, claim_d;
  logic       wr_q;
  logic       has_res_q;

  // Result register
  logic [7:0] read_data_q;
  logic       claimed_q;

  // Decode
  logic vram_sel, wram_sel, spr_sel, hram_sel, bpal_sel, opal_sel;
  logic vbank_we, wbank_we, bpi_we, opi_we, ie_we;

  logic [VRAM_AW-1:0]   vram_addr;
  logic [WRAM_AW-1:0]   wram_addr;
  logic [SPRITE_AW-1:0] spr_addr;
  logic [HRAM_AW-1:0]   hram_addr;
  logic [PAL_AW-1:0]    bpal_addr, opal_addr;

  logic [7:0] vram_rd, wram_rd, spr_rd, hram_rd, bpal_rd, opal_rd;
  logic [7:0] rd_mux;

  always_comb begin
    src_d    = SRC_FIXED;
    fix_d    = BYTE_OPEN;
    claim_d  = 1'b1;
    vram_sel = 1'b0;
    wram_sel = 1'b0;
    spr_sel  = 1'b0;
    hram_sel = 1'b0;
    bpal_sel = 1'b0;
    opal_sel = 1'b0;
    vbank_we = 1'b0;
    wbank_we = 1'b0;
    bpi_we   = 1'b0;
    opi_we   = 1'b0;
    ie_we    = 1'b0;

    if (!bus_address_i[15]) begin
      claim_d = 1'b0;
    end else if (bus_address_i < ADDR_CART) begin
      vram_sel = 1'b1;
      src_d    = SRC_VRAM;
    end else if (bus_address_i < ADDR_WRAM) begin
      claim_d = 1'b0;
    end else if (bus_address_i < ADDR_SPRITE) begin
      wram_sel = 1'b1;
      src_d    = SRC_WRAM;
    end else if (bus_address_i < ADDR_IO) begin
      // unusable tail reads open bus, still claimed
      if (bus_address_i < ADDR_SPRITE_END) begin
        spr_sel = 1'b1;
        src_d   = SRC_SPRITE;
      end
    end else if (bus_address_i == ADDR_IE) begin
      ie_we = req_type_i;
      fix_d = ie_q;
    end else if (bus_address_i[7]) begin
      hram_sel = 1'b1;
      src_d    = SRC_HRAM;
    end else if (!color_mode_q) begin
      claim_d = 1'b0;
    end else begin
      case (bus_address_i)
        ADDR_VBANK: begin
          vbank_we = req_type_i;
          fix_d    = {7'h7F, vbank_q};
        end
        ADDR_BPI: begin
          bpi_we = req_type_i;
          fix_d  = bpi_q;
        end
        ADDR_BPD: begin
          bpal_sel = 1'b1;
          src_d    = SRC_BPAL;
        end
        ADDR_OPI: begin
          opi_we = req_type_i;
          fix_d  = opi_q;
        end
        ADDR_OPD: begin
          opal_sel = 1'b1;
          src_d    = SRC_OPAL;
        end
        ADDR_WBANK: begin
          wbank_we = req_type_i;
          fix_d    = {5'h1F, wbank_q};
        end
        default: claim_d = 1'b0;
      endcase
    end
  end

  // Memory addresses
  always_comb begin
    vram_addr = {vbank_q, bus_address_i[12:0]};
    if (bus_address_i >= ADDR_ECHO) begin
      wram_addr = WRAM_AW'(bus_address_i[12:0]);  // echo: raw offset, no banking
    end else if (bus_address_i >= ADDR_WRAM_SW) begin
      wram_addr = {wram_bank_wrap(wbank_q), bus_address_i[11:0]};
    end else begin
      wram_addr = WRAM_AW'(bus_address_i[11:0]);
    end
    spr_addr  = bus_address_i[SPRITE_AW-1:0];
    hram_addr = bus_address_i[HRAM_AW-1:0];
    bpal_addr = pal_wrap(bpi_q[5:0]);
    opal_addr = pal_wrap(opi_q[5:0]);
  end

  bvwpm_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
    .clk_i, .en_i(cmd_i.issue && vram_sel), .we_i(req_type_i),
    .addr_i(vram_addr), .wdata_i(write_data_i), .rdata_o(vram_rd)
  );

  bvwpm_ram #(.WIDTH(8), .DEPTH(WRAM_DEPTH)) u_wram (
    .clk_i, .en_i(cmd_i.issue && wram_sel), .we_i(req_type_i),
    .addr_i(wram_addr), .wdata_i(write_data_i), .rdata_o(wram_rd)
  );

  bvwpm_ram #(.WIDTH(8), .DEPTH(SPRITE_DEPTH)) u_sprite (
    .clk_i, .en_i(cmd_i.issue && spr_sel), .we_i(req_type_i),
    .addr_i(spr_addr), .wdata_i(write_data_i), .rdata_o(spr_rd)
  );

  bvwpm_ram #(.WIDTH(8), .DEPTH(HRAM_DEPTH)) u_hram (
    .clk_i, .en_i(cmd_i.issue && hram_sel), .we_i(req_type_i),
    .addr_i(hram_addr), .wdata_i(write_data_i), .rdata_o(hram_rd)
  );

  bvwpm_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_bpal (
    .clk_i, .en_i(cmd_i.issue && bpal_sel), .we_i(req_type_i),
    .addr_i(bpal_addr), .wdata_i(write_data_i), .rdata_o(bpal_rd)
  );

  bvwpm_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_opal (
    .clk_i, .en_i(cmd_i.issue && opal_sel), .we_i(req_type_i),
    .addr_i(opal_addr), .wdata_i(write_data_i), .rdata_o(opal_rd)
  );

  // Registers, palette auto-increment and access capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b1;
      vbank_q      <= 1'b0;
      wbank_q      <= 3'd0;
      bpi_q        <= 8'h00;
      opi_q        <= 8'h00;
      ie_q         <= 8'h00;
      has_res_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) color_mode_q <= cfg_color_mode_i;
      if (cmd_i.issue) begin
        has_res_q <= bus_address_i[15];
        if (vbank_we) vbank_q <= write_data_i[0];
        if (wbank_we) wbank_q <= write_data_i[2:0];
        if (ie_we)    ie_q    <= write_data_i;
        if (bpi_we) begin
          bpi_q <= write_data_i;
        end else if (bpal_sel && req_type_i && bpi_q[7]) begin
          bpi_q <= {2'b10, pal_next(bpal_addr)};
        end
        if (opi_we) begin
          opi_q <= write_data_i;
        end else if (opal_sel && req_type_i && opi_q[7]) begin
          opi_q <= {2'b10, pal_next(opal_addr)};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      src_q   <= src_d;
      fix_q   <= fix_d;
      claim_q <= claim_d;
      wr_q    <= req_type_i;
    end
  end

  always_comb begin
    case (src_q)
      SRC_FIXED:  rd_mux = fix_q;
      SRC_VRAM:   rd_mux = vram_rd;
      SRC_WRAM:   rd_mux = wram_rd;
      SRC_SPRITE: rd_mux = spr_rd;
      SRC_HRAM:   rd_mux = hram_rd;
      SRC_BPAL:   rd_mux = bpal_rd;
      SRC_OPAL:   rd_mux = opal_rd;
      default:    rd_mux = BYTE_OPEN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      read_data_q <= wr_q ? 8'h00 : rd_mux;
      claimed_q   <= claim_q;
    end
  end

  assign status_o.has_result = has_res_q;
  assign read_data_o         = read_data_q;
  assign claimed_o           = claimed_q;

endmodule

// ===== rtl/banked_vram_wram_palette_map.sv =====
// Top level of the banked video/work RAM and palette memory map.
//
//  port   | dir | word                                  | accepted when
//  req_i  | in  | req_type, bus_address, write_data     | valid && ready
//  rsp_o  | out | read_data, claimed                    | valid && ready
//  cfg_i  | in  | color_mode                            | valid && ready (ready tied high)
//
// Each access is sequenced: the accept cycle decodes and drives the RAM port,
// then the response cycle takes the registered RAM read data into the output
// register. One access is in flight at a time; a new word is accepted while
// the previous result still waits in the output register, and the block holds
// in its response cycle while that register is full and not taken.
// Accesses below 0x8000 give no result. Reset clears the bank, palette index
// and interrupt-enable registers and sets colour mode; RAM contents are left
// as they are, with no clearing pass.
module banked_vram_wram_palette_map
  import bvwpm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  bvwpm_req_if.sink   req_i,
  bvwpm_rsp_if.source rsp_o,
  bvwpm_cfg_if.sink   cfg_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // user changes colour mode only while idle (not enforced); writes are always taken
  assign cfg_i.ready = 1'b1;

  // sequencing: accept -> access -> load result
  bvwpm_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // decode, memories, registers and the output word
  bvwpm_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (req_i.req_type),
    .bus_address_i   (req_i.bus_address),
    .write_data_i    (req_i.write_data),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_color_mode_i(cfg_i.color_mode),
    .read_data_o     (rsp_o.read_data),
    .claimed_o       (rsp_o.claimed)
  );

  // one access at a time: no accept on the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second word accepted while an access is in flight");

  // an access below 0x8000 must not raise a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && !req_i.bus_address[15] && !rsp_o.valid)
      |=> !rsp_o.valid ##1 !rsp_o.valid)
    else $error("result produced for an access below 0x8000");

  // an unclaimed word reads open bus, or zero for a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.claimed) |->
      (rsp_o.read_data == BYTE_OPEN || rsp_o.read_data == 8'h00))
    else $error("unclaimed access returned memory data");

endmodule
